### src/chtab_pkg.sv
// Shared types, codes and sizes for the chained hash table core.
// No dependencies; imported by every module of the block.
`default_nettype none

package chtab_pkg;

  localparam int unsigned DEFAULT_BUCKETS = 256;
  localparam int unsigned POOL_SIZE       = 256;
  localparam int unsigned NODE_W          = 8;
  localparam int unsigned CNT_W           = 9;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned STATUS_W        = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] first;
  } bkt_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [NODE_W-1:0] link;
    logic              link_valid;
  } ent_word_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    ent_word_t         data;
  } ent_wr_t;

endpackage

`default_nettype wire

### src/chtab_bucket_mem.sv
// Bucket head memory: one word per bucket holding the head node and a valid bit.
// Synchronous, one write and one registered read per cycle. Depends on chtab_pkg.
`default_nettype none

module chtab_bucket_mem
  import chtab_pkg::*;
#(
  parameter int unsigned BUCKETS = DEFAULT_BUCKETS,
  localparam int unsigned BKT_AW = $clog2(BUCKETS)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [BKT_AW-1:0] wr_addr,
  input  wire bkt_word_t         wr_data,
  input  wire logic              rd_en,
  input  wire logic [BKT_AW-1:0] rd_addr,
  output bkt_word_t              rd_data
);

  bkt_word_t mem_r [BUCKETS];
  bkt_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### src/chtab_entry_mem.sv
// Node pool memory: key, value and chain link of each pool slot.
// Synchronous, one write and one registered read per cycle. Depends on chtab_pkg.
`default_nettype none

module chtab_entry_mem
  import chtab_pkg::*;
(
  input  wire logic              clk,
  input  wire ent_wr_t           wr,
  input  wire logic              rd_en,
  input  wire logic [NODE_W-1:0] rd_addr,
  output ent_word_t              rd_data
);

  ent_word_t mem_r [POOL_SIZE];
  ent_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### src/chained_hash_table_core.sv
// Chained hash table core: sequencer over the bucket memory and the node pool.
// Insert: bucket read (S_BKT), then head read and node write (S_HEAD), then out_valid.
// Search: same reads, plus an entry read per further chain node walked (S_NODE).
// A new item is taken in the cycle its result beat is shown; the receiver cannot stall.
// Clear and refused insert answer from idle. After reset, busy stays high while the bucket
// memory is swept empty. Depends on chtab_pkg, chtab_bucket_mem, chtab_entry_mem.
`default_nettype none

module chained_hash_table_core
  import chtab_pkg::*;
#(
  parameter int unsigned BUCKETS = DEFAULT_BUCKETS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic [VAL_W-1:0]    in_value,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic [NODE_W-1:0]        out_node_index,
  output logic [VAL_W-1:0]         out_value_out
);

  localparam int unsigned BKT_AW = $clog2(BUCKETS);
  localparam int unsigned CAP    = (BUCKETS < POOL_SIZE) ? BUCKETS : POOL_SIZE;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_BKT  = 3'd2;
  localparam logic [2:0] S_HEAD = 3'd3;
  localparam logic [2:0] S_NODE = 3'd4;

  logic [2:0]          state_r,   state_nxt;
  logic [OP_W-1:0]     op_r,      op_nxt;
  logic [KEY_W-1:0]    key_r,     key_nxt;
  logic [VAL_W-1:0]    val_r,     val_nxt;
  logic [NODE_W-1:0]   node_r,    node_nxt;
  logic                bvalid_r,  bvalid_nxt;
  logic [CNT_W-1:0]    cnt_r,     cnt_nxt;
  logic [BKT_AW-1:0]   clr_r,     clr_nxt;
  logic                ovalid_r,  ovalid_nxt;
  logic [STATUS_W-1:0] ostatus_r, ostatus_nxt;
  logic [NODE_W-1:0]   onode_r,   onode_nxt;
  logic [VAL_W-1:0]    ovalue_r,  ovalue_nxt;

  logic              bkt_wr_en;
  logic [BKT_AW-1:0] bkt_wr_addr;
  bkt_word_t         bkt_wr_data;
  logic              bkt_rd_en;
  logic [BKT_AW-1:0] bkt_rd_addr;
  bkt_word_t         bkt_rd_data;

  ent_wr_t           ent_wr;
  logic              ent_rd_en;
  logic [NODE_W-1:0] ent_rd_addr;
  ent_word_t         ent_rd_data;

  logic full;
  logic head_live;
  logic key_hit;

  chtab_bucket_mem #(
    .BUCKETS (BUCKETS)
  ) u_bkt (
    .clk     (clk),
    .wr_en   (bkt_wr_en),
    .wr_addr (bkt_wr_addr),
    .wr_data (bkt_wr_data),
    .rd_en   (bkt_rd_en),
    .rd_addr (bkt_rd_addr),
    .rd_data (bkt_rd_data)
  );

  chtab_entry_mem u_ent (
    .clk     (clk),
    .wr      (ent_wr),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rd_data)
  );

  assign full    = (cnt_r >= CNT_W'(CAP));
  assign key_hit = (ent_rd_data.key == key_r);
  // A stale head from before a clear is rejected: a live head points below the fill
  // count at a node whose key falls in this bucket.
  assign head_live = bvalid_r && ({1'b0, node_r} < cnt_r) &&
                     (ent_rd_data.key[BKT_AW-1:0] == key_r[BKT_AW-1:0]);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    node_nxt    = node_r;
    bvalid_nxt  = bvalid_r;
    cnt_nxt     = cnt_r;
    clr_nxt     = clr_r;
    ovalid_nxt  = 1'b0;
    ostatus_nxt = ostatus_r;
    onode_nxt   = onode_r;
    ovalue_nxt  = ovalue_r;

    bkt_wr_en         = 1'b0;
    bkt_wr_addr       = key_r[BKT_AW-1:0];
    bkt_wr_data.valid = 1'b1;
    bkt_wr_data.first = cnt_r[NODE_W-1:0];
    bkt_rd_en         = 1'b0;
    bkt_rd_addr       = in_key[BKT_AW-1:0];

    ent_wr.en              = 1'b0;
    ent_wr.addr            = cnt_r[NODE_W-1:0];
    ent_wr.data.key        = key_r;
    ent_wr.data.value      = val_r;
    ent_wr.data.link       = node_r;
    ent_wr.data.link_valid = head_live;
    ent_rd_en              = 1'b0;
    ent_rd_addr            = bkt_rd_data.first;

    case (state_r)
      S_INIT: begin
        bkt_wr_en   = 1'b1;
        bkt_wr_addr = clr_r;
        bkt_wr_data = '0;
        clr_nxt     = clr_r + 1'b1;
        if (clr_r == BKT_AW'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_op;
          key_nxt = in_key;
          val_nxt = in_value;
          case (in_op)
            OP_INSERT: begin
              if (full) begin
                ovalid_nxt  = 1'b1;
                ostatus_nxt = ST_FULL;
                onode_nxt   = '0;
                ovalue_nxt  = '0;
              end else begin
                bkt_rd_en = 1'b1;
                state_nxt = S_BKT;
              end
            end
            OP_SEARCH: begin
              bkt_rd_en = 1'b1;
              state_nxt = S_BKT;
            end
            OP_CLEAR: begin
              cnt_nxt     = '0;
              ovalid_nxt  = 1'b1;
              ostatus_nxt = ST_OK;
              onode_nxt   = '0;
              ovalue_nxt  = '0;
            end
            default: begin
              ovalid_nxt  = 1'b1;
              ostatus_nxt = ST_OK;
              onode_nxt   = '0;
              ovalue_nxt  = '0;
            end
          endcase
        end
      end
      S_BKT: begin
        node_nxt    = bkt_rd_data.first;
        bvalid_nxt  = bkt_rd_data.valid;
        ent_rd_en   = 1'b1;
        ent_rd_addr = bkt_rd_data.first;
        state_nxt   = S_HEAD;
      end
      S_HEAD, S_NODE: begin
        if (state_r == S_HEAD && op_r == OP_INSERT) begin
          ent_wr.en   = 1'b1;
          bkt_wr_en   = 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_OK;
          onode_nxt   = cnt_r[NODE_W-1:0];
          ovalue_nxt  = '0;
          state_nxt   = S_IDLE;
        end else if (state_r == S_HEAD && !head_live) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_MISS;
          onode_nxt   = '0;
          ovalue_nxt  = '0;
          state_nxt   = S_IDLE;
        end else if (key_hit) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_OK;
          onode_nxt   = node_r;
          ovalue_nxt  = ent_rd_data.value;
          state_nxt   = S_IDLE;
        end else if (ent_rd_data.link_valid) begin
          node_nxt    = ent_rd_data.link;
          ent_rd_en   = 1'b1;
          ent_rd_addr = ent_rd_data.link;
          state_nxt   = S_NODE;
        end else begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_MISS;
          onode_nxt   = '0;
          ovalue_nxt  = '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      cnt_r    <= '0;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
    end
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    node_r    <= node_nxt;
    bvalid_r  <= bvalid_nxt;
    ostatus_r <= ostatus_nxt;
    onode_r   <= onode_nxt;
    ovalue_r  <= ovalue_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = ovalid_r;
  assign out_status     = ostatus_r;
  assign out_node_index = onode_r;
  assign out_value_out  = ovalue_r;

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAP))
    else $error("fill count above capacity");

  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> (busy && !out_valid))
    else $error("result or accept during bucket sweep");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_node_index == '0 && out_value_out == '0))
    else $error("nonzero payload on miss or full");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HEAD && op_r == OP_INSERT) |=>
      (out_valid && out_status == ST_OK && cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not advance fill count");

endmodule

`default_nettype wire

### test/tb_chained_hash_table_core.sv
`timescale 1ns / 100ps
// Testbench for chained_hash_table_core: sends insert, search, clear and unused-op beats and
// checks every result beat against a table model kept here. Depends on chtab_pkg and the core.

module tb_chained_hash_table_core;
  import chtab_pkg::*;

  localparam int unsigned TABLE_BUCKETS = DEFAULT_BUCKETS;
  localparam int unsigned TABLE_CAP     = (TABLE_BUCKETS < POOL_SIZE) ? TABLE_BUCKETS : POOL_SIZE;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 3000000;
  localparam int unsigned DRAIN_CYCLES  = POOL_SIZE + 40;
  localparam int unsigned MAX_GAP       = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node_index;
    logic [VAL_W-1:0]    value;
  } answer_t;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              start    = 1'b0;
  logic [OP_W-1:0]   in_op    = OP_INSERT;
  logic [KEY_W-1:0]  in_key   = '0;
  logic [VAL_W-1:0]  in_value = '0;
  logic              busy;
  logic              out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [NODE_W-1:0] out_node_index;
  logic [VAL_W-1:0]  out_value_out;

  chained_hash_table_core #(.BUCKETS(TABLE_BUCKETS)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_node_index(out_node_index),
    .out_value_out (out_value_out)
  );

  always #5 clk = ~clk;

  bit                bkt_live [TABLE_BUCKETS];
  bit [NODE_W-1:0]   bkt_head [TABLE_BUCKETS];
  bit [KEY_W-1:0]    node_key [POOL_SIZE];
  bit [VAL_W-1:0]    node_value [POOL_SIZE];
  bit [NODE_W-1:0]   node_next [POOL_SIZE];
  bit                node_next_live [POOL_SIZE];
  int unsigned       nodes_used = 0;

  answer_t           pending_answers[$];
  logic [KEY_W-1:0]  live_keys[$];
  int unsigned       idle_pct = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;

  function automatic answer_t predict_table_answer(logic [OP_W-1:0] op,
                                                   logic [KEY_W-1:0] key,
                                                   logic [VAL_W-1:0] value);
    answer_t     ans;
    int unsigned b;
    int unsigned node;
    int unsigned steps;
    bit          live;
    ans = '0;
    b = key & (TABLE_BUCKETS - 1);
    case (op)
      OP_INSERT: begin
        if (nodes_used >= TABLE_CAP) begin
          ans.status = ST_FULL;
        end else begin
          node_key[nodes_used]       = key;
          node_value[nodes_used]     = value;
          node_next[nodes_used]      = bkt_head[b];
          node_next_live[nodes_used] = bkt_live[b];
          bkt_head[b]                = NODE_W'(nodes_used);
          bkt_live[b]                = 1'b1;
          ans.status                 = ST_OK;
          ans.node_index             = NODE_W'(nodes_used);
          nodes_used++;
          live_keys.push_back(key);
        end
      end
      OP_SEARCH: begin
        ans.status = ST_MISS;
        live  = bkt_live[b];
        node  = bkt_head[b];
        steps = 0;
        while (live && steps < POOL_SIZE) begin
          if (node_key[node] == key) begin
            ans.status     = ST_OK;
            ans.node_index = NODE_W'(node);
            ans.value      = node_value[node];
            live           = 1'b0;
          end else begin
            live = node_next_live[node];
            node = node_next[node];
          end
          steps++;
        end
      end
      OP_CLEAR: begin
        foreach (bkt_live[i]) bkt_live[i] = 1'b0;
        nodes_used = 0;
        live_keys.delete();
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    answer_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("result beat with nothing pending", 32'(out_status), '0);
        end else begin
          want = pending_answers.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_node_index !== want.node_index)
            report_mismatch("node_index", 32'(out_node_index), 32'(want.node_index));
          if (out_value_out !== want.value)
            report_mismatch("value_out", out_value_out, want.value);
        end
      end
      if (start && !busy)
        pending_answers.push_back(predict_table_answer(in_op, in_key, in_value));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_chained_hash_table_core failed");
      $finish;
    end
  end

  task automatic send_beat(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                           logic [VAL_W-1:0] value);
    int unsigned gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < MAX_GAP) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
    start    <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(bit want_hit);
    logic [7:0]       tag;
    logic [KEY_W-1:0] key;
    int unsigned      r;
    r = $urandom_range(99);
    if (live_keys.size() != 0 && (want_hit ? r < 65 : r < 30))
      return live_keys[$urandom_range(live_keys.size() - 1)];
    r = $urandom_range(99);
    key = $urandom;
    if (r < 60) begin
      case ($urandom_range(3))
        0: tag = 8'h00;
        1: tag = 8'h5A;
        2: tag = 8'hA5;
        default: tag = 8'hFF;
      endcase
      key[7:0] = tag;
    end
    return key;
  endfunction

  task automatic test_basic_ops();
    send_beat(OP_SEARCH, 32'h0000_0000, 32'h0);
    send_beat(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_SEARCH, 32'h0000_0000, 32'h0);
    send_beat(OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_beat(OP_SEARCH, 32'h0000_0100, 32'h0);
    send_beat(OP_INSERT, 32'h0000_0100, 32'h1234_5678);
    send_beat(OP_INSERT, 32'h0000_0000, 32'h8765_4321);
    send_beat(OP_SEARCH, 32'h0000_0000, 32'h0);
    send_beat(OP_SEARCH, 32'h0000_0100, 32'h0);
    send_beat(OP_SEARCH, 32'h1234_5677, 32'h0);
    send_beat(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_beat(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_SEARCH, 32'h0000_0000, 32'h0);
    send_beat(OP_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_beat(OP_SEARCH, 32'hA5A5_A5A5, 32'h0);
  endtask

  task automatic test_full_table();
    send_beat(OP_CLEAR, 32'h0, 32'h0);
    for (int i = 0; i < TABLE_CAP; i++)
      send_beat(OP_INSERT, {24'(i), 8'h5A}, $urandom);
    send_beat(OP_SEARCH, {24'd0, 8'h5A}, 32'h0);
    send_beat(OP_SEARCH, {24'hFF_FFFF, 8'h5A}, 32'h0);
    send_beat(OP_INSERT, 32'h0000_0001, 32'hFFFF_FFFF);
    send_beat(OP_SEARCH, 32'h0000_0001, 32'h0);
    send_beat(OP_SEARCH, {24'(TABLE_CAP - 1), 8'h5A}, 32'h0);
    send_beat(OP_CLEAR, 32'h0, 32'h0);
    send_beat(OP_SEARCH, {24'd7, 8'h5A}, 32'h0);
  endtask

  task automatic test_random_traffic(int unsigned beats);
    int unsigned r;
    for (int unsigned n = 0; n < beats; n++) begin
      r = $urandom_range(99);
      if (r < 46)
        send_beat(OP_INSERT, pick_key(1'b0), $urandom);
      else if (r < 94)
        send_beat(OP_SEARCH, pick_key(1'b1), $urandom);
      else if (r < 97)
        send_beat(OP_CLEAR, $urandom, $urandom);
      else
        send_beat(OP_UNUSED, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 24;
    test_basic_ops();
    test_full_table();
    test_random_traffic(480);
    idle_pct = 84;
    test_random_traffic(480);
    idle_pct = 0;
    test_random_traffic(480);

    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch("results never delivered", pending_answers.size(), '0);
    if (mismatches == 0)
      $display("tb_chained_hash_table_core passed");
    else
      $display("tb_chained_hash_table_core failed");
    $finish;
  end

endmodule

### sim.f
src/chtab_pkg.sv
src/chtab_bucket_mem.sv
src/chtab_entry_mem.sv
src/chained_hash_table_core.sv
test/tb_chained_hash_table_core.sv
